FILE: hdl/tov_pkg.sv
// Package with the transaction types and constants of the TCP option validator.
package tov_pkg;

    // Option limits.
    localparam int unsigned MAX_OPTIONS    = 10;
    localparam int unsigned MAX_OPTION_LEN = 40;
    localparam int unsigned MIN_OPTION_LEN = 2;

    // Field widths.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned BODY_W  = 6;

    // Option kinds that get special handling.
    localparam logic [BYTE_W-1:0] KIND_EOL    = 8'd0;
    localparam logic [BYTE_W-1:0] KIND_NOP    = 8'd1;
    localparam logic [BYTE_W-1:0] KIND_MSS    = 8'd2;
    localparam logic [BYTE_W-1:0] KIND_WSCALE = 8'd3;
    localparam logic [BYTE_W-1:0] KIND_SACKOK = 8'd4;

    // Exact lengths required for the known kinds.
    localparam logic [BYTE_W-1:0] LEN_MSS    = 8'd4;
    localparam logic [BYTE_W-1:0] LEN_WSCALE = 8'd3;
    localparam logic [BYTE_W-1:0] LEN_SACKOK = 8'd2;

    // Input action codes.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Verdict codes.
    localparam logic VERDICT_VALID   = 1'b0;
    localparam logic VERDICT_INVALID = 1'b1;

    // One input transaction.
    typedef struct packed {
        logic              action;
        logic [BYTE_W-1:0] option_byte;
    } in_t;

    // One result transaction.
    typedef struct packed {
        logic               verdict;
        logic [COUNT_W-1:0] options_seen;
    } out_t;

endpackage

FILE: hdl/tov_parser.sv
// Option parser: holds the per-area state and evaluates one byte per step.
module tov_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  tov_pkg::in_t  item,
    output logic          result_valid,
    output tov_pkg::out_t result
);

    typedef enum logic [1:0] {
        PH_KIND = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    phase_t                           phase_reg, phase_next;
    logic                             decided_reg, decided_next;
    logic                             decided_invalid_reg, decided_invalid_next;
    logic [tov_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [tov_pkg::BYTE_W-1:0]       kind_reg, kind_next;
    logic [tov_pkg::BODY_W-1:0]       body_reg, body_next;

    logic [tov_pkg::COUNT_W-1:0]      count_inc;
    logic [tov_pkg::BYTE_W-1:0]       len_minus;
    logic [tov_pkg::BODY_W-1:0]       body_dec;
    logic                             len_bad;
    logic                             in_option;

    // Arithmetic used by the phases and the verdict.
    assign count_inc = count_reg + tov_pkg::COUNT_W'(1);
    assign len_minus = item.option_byte - tov_pkg::BYTE_W'(tov_pkg::MIN_OPTION_LEN);
    assign body_dec  = body_reg - tov_pkg::BODY_W'(1);
    assign in_option = (phase_reg == PH_LEN) || (phase_reg == PH_BODY);

    // Length byte check: general range plus exact lengths for known kinds.
    always_comb
    begin
        len_bad = (item.option_byte < tov_pkg::BYTE_W'(tov_pkg::MIN_OPTION_LEN))
               || (item.option_byte > tov_pkg::BYTE_W'(tov_pkg::MAX_OPTION_LEN));
        if (kind_reg == tov_pkg::KIND_MSS && item.option_byte != tov_pkg::LEN_MSS)
            len_bad = 1'b1;
        if (kind_reg == tov_pkg::KIND_WSCALE && item.option_byte != tov_pkg::LEN_WSCALE)
            len_bad = 1'b1;
        if (kind_reg == tov_pkg::KIND_SACKOK && item.option_byte != tov_pkg::LEN_SACKOK)
            len_bad = 1'b1;
    end

    // Next state and verdict for the transaction in hand.
    always_comb
    begin
        phase_next           = phase_reg;
        decided_next         = decided_reg;
        decided_invalid_next = decided_invalid_reg;
        count_next           = count_reg;
        kind_next            = kind_reg;
        body_next            = body_reg;
        result_valid         = 1'b0;
        result.verdict       = decided_reg ? decided_invalid_reg : in_option;
        result.options_seen  = count_reg;

        if (step)
        begin
            if (item.action == tov_pkg::ACT_END)
            begin
                // End of the area: report and return to the reset state.
                result_valid         = 1'b1;
                phase_next           = PH_KIND;
                decided_next         = 1'b0;
                decided_invalid_next = 1'b0;
                count_next           = '0;
                kind_next            = '0;
                body_next            = '0;
            end
            else if (!decided_reg)
            begin
                unique case (phase_reg)
                    PH_LEN:
                    begin
                        if (len_bad)
                        begin
                            decided_next         = 1'b1;
                            decided_invalid_next = tov_pkg::VERDICT_INVALID;
                        end
                        else
                        begin
                            body_next = len_minus[tov_pkg::BODY_W-1:0];
                            if (len_minus == '0)
                            begin
                                phase_next = PH_KIND;
                                if (count_reg >= tov_pkg::COUNT_W'(tov_pkg::MAX_OPTIONS))
                                begin
                                    decided_next         = 1'b1;
                                    decided_invalid_next = tov_pkg::VERDICT_INVALID;
                                end
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                    end
                    PH_BODY:
                    begin
                        body_next = body_dec;
                        if (body_dec == '0)
                        begin
                            phase_next = PH_KIND;
                            if (count_reg >= tov_pkg::COUNT_W'(tov_pkg::MAX_OPTIONS))
                            begin
                                decided_next         = 1'b1;
                                decided_invalid_next = tov_pkg::VERDICT_INVALID;
                            end
                        end
                    end
                    default:
                    begin
                        // Expecting a kind byte; the unused phase code acts the same.
                        if (item.option_byte == tov_pkg::KIND_EOL)
                        begin
                            phase_next           = PH_KIND;
                            decided_next         = 1'b1;
                            decided_invalid_next = tov_pkg::VERDICT_VALID;
                        end
                        else
                        begin
                            count_next = count_inc;
                            kind_next  = item.option_byte;
                            if (item.option_byte == tov_pkg::KIND_NOP)
                            begin
                                phase_next = PH_KIND;
                                if (count_inc >= tov_pkg::COUNT_W'(tov_pkg::MAX_OPTIONS))
                                begin
                                    decided_next         = 1'b1;
                                    decided_invalid_next = tov_pkg::VERDICT_INVALID;
                                end
                            end
                            else
                            begin
                                phase_next = PH_LEN;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_KIND;
            decided_reg         <= 1'b0;
            decided_invalid_reg <= 1'b0;
            count_reg           <= '0;
            kind_reg            <= '0;
            body_reg            <= '0;
        end
        else
        begin
            phase_reg           <= phase_next;
            decided_reg         <= decided_next;
            decided_invalid_reg <= decided_invalid_next;
            count_reg           <= count_next;
            kind_reg            <= kind_next;
            body_reg            <= body_next;
        end
    end

endmodule

FILE: hdl/tcp_option_validator.sv
// Top level of the TCP option validator: input register, parser and result register.
// Checks the option area of a TCP SYN segment one byte per transaction and gives one
// verdict (valid or drop) with the number of options started when the end-of-area
// transaction arrives, then clears itself for the next segment. A new transaction is
// taken every cycle unless the input register waits; the verdict of an end transaction
// is registered in the result register once the parser takes it. The input register
// waits only while it holds an end transaction and the result register still holds an
// earlier verdict that has not been taken; option bytes never wait.
module tcp_option_validator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tov_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output tov_pkg::out_t out_data
);

    logic          in_full_reg, in_full_next;
    tov_pkg::in_t  in_data_reg;
    logic          out_valid_reg, out_valid_next;
    tov_pkg::out_t out_data_reg;

    logic          advance;
    logic          result_valid;
    tov_pkg::out_t result;

    // The held transaction moves on unless it is an end marker blocked by a full output.
    assign advance  = in_full_reg
                   && ((in_data_reg.action != tov_pkg::ACT_END) || !out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || advance;

    // Per-byte parser.
    tov_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (in_data_reg),
        .result_valid (result_valid),
        .result       (result)
    );

    // Occupancy of the input and result registers.
    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_valid && in_ready)
            in_full_next = 1'b1;
        else if (advance)
            in_full_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (result_valid)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
        if (result_valid)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: dv/tov_checker.sv
// Checker for the TCP option validator: predicts each verdict and compares it with the output.
module tov_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  tov_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  tov_pkg::out_t out_data,
    output int            fail_count,
    output int            pending,
    output int            valid_verdicts,
    output int            invalid_verdicts
);

    // Where the parser stands inside the option area.
    typedef enum logic [1:0] {
        EXPECT_KIND = 2'd0,
        EXPECT_LEN  = 2'd1,
        IN_BODY     = 2'd2
    } parse_phase_t;

    // Shadow copy of the parser state.
    parse_phase_t                parse_phase;
    logic                        verdict_known;
    logic                        known_verdict;
    logic [tov_pkg::COUNT_W-1:0] opt_count;
    logic [tov_pkg::BYTE_W-1:0]  opt_kind;
    logic [tov_pkg::BODY_W-1:0]  body_left;

    // Verdicts predicted but not yet seen on the output, oldest first.
    tov_pkg::out_t verdict_q[$];
    tov_pkg::out_t want;
    int            errs;
    int            n_valid;
    int            n_invalid;

    // Back to the state of a fresh segment.
    task automatic clear_parser();
        parse_phase   = EXPECT_KIND;
        verdict_known = 1'b0;
        known_verdict = tov_pkg::VERDICT_VALID;
        opt_count     = '0;
        opt_kind      = '0;
        body_left     = '0;
    endtask

    // An option has been read in full; the tenth one makes the area invalid.
    task automatic finish_option();
        parse_phase = EXPECT_KIND;
        if (opt_count >= tov_pkg::MAX_OPTIONS)
        begin
            verdict_known = 1'b1;
            known_verdict = tov_pkg::VERDICT_INVALID;
        end
    endtask

    // Advance the shadow parser by one transaction and queue a verdict on the end marker.
    task automatic parse_option_byte(input tov_pkg::in_t t);
        logic          bad_len;
        tov_pkg::out_t v;
        if (t.action == tov_pkg::ACT_END)
        begin
            if (verdict_known)
                v.verdict = known_verdict;
            else if (parse_phase == EXPECT_LEN || parse_phase == IN_BODY)
                v.verdict = tov_pkg::VERDICT_INVALID;
            else
                v.verdict = tov_pkg::VERDICT_VALID;
            v.options_seen = opt_count;
            verdict_q.push_back(v);
            if (v.verdict == tov_pkg::VERDICT_VALID)
                n_valid++;
            else
                n_invalid++;
            clear_parser();
        end
        else if (!verdict_known)
        begin
            unique case (parse_phase)
                EXPECT_LEN:
                begin
                    bad_len = (t.option_byte < tov_pkg::MIN_OPTION_LEN) ||
                              (t.option_byte > tov_pkg::MAX_OPTION_LEN);
                    if (opt_kind == tov_pkg::KIND_MSS && t.option_byte != tov_pkg::LEN_MSS)
                        bad_len = 1'b1;
                    if (opt_kind == tov_pkg::KIND_WSCALE
                        && t.option_byte != tov_pkg::LEN_WSCALE)
                        bad_len = 1'b1;
                    if (opt_kind == tov_pkg::KIND_SACKOK
                        && t.option_byte != tov_pkg::LEN_SACKOK)
                        bad_len = 1'b1;
                    if (bad_len)
                    begin
                        verdict_known = 1'b1;
                        known_verdict = tov_pkg::VERDICT_INVALID;
                    end
                    else
                    begin
                        body_left = tov_pkg::BODY_W'(t.option_byte - tov_pkg::MIN_OPTION_LEN);
                        if (body_left == '0)
                            finish_option();
                        else
                            parse_phase = IN_BODY;
                    end
                end
                IN_BODY:
                begin
                    body_left = body_left - 1'b1;
                    if (body_left == '0)
                        finish_option();
                end
                default:
                begin
                    // A kind byte: end-of-list settles the area as valid.
                    if (t.option_byte == tov_pkg::KIND_EOL)
                    begin
                        parse_phase   = EXPECT_KIND;
                        verdict_known = 1'b1;
                        known_verdict = tov_pkg::VERDICT_VALID;
                    end
                    else
                    begin
                        opt_count = opt_count + 1'b1;
                        opt_kind  = t.option_byte;
                        if (t.option_byte == tov_pkg::KIND_NOP)
                            finish_option();
                        else
                            parse_phase = EXPECT_LEN;
                    end
                end
            endcase
        end
    endtask

    // Compare results first; a verdict can never leave in the cycle its end marker enters.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            verdict_q.delete();
            errs             = 0;
            n_valid          = 0;
            n_invalid        = 0;
            fail_count       <= 0;
            pending          <= 0;
            valid_verdicts   <= 0;
            invalid_verdicts <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    if (errs < 10)
                        $display("[%0t] unexpected verdict: verdict=%b options_seen=%0d",
                                 $realtime, out_data.verdict, out_data.options_seen);
                    errs++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (out_data.verdict !== want.verdict ||
                        out_data.options_seen !== want.options_seen)
                    begin
                        if (errs < 10)
                            $display({"[%0t] verdict mismatch: expected verdict=%b ",
                                      "options_seen=%0d, got verdict=%b options_seen=%0d"},
                                     $realtime, want.verdict, want.options_seen,
                                     out_data.verdict, out_data.options_seen);
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
                parse_option_byte(in_data);
            fail_count       <= errs;
            pending          <= verdict_q.size();
            valid_verdicts   <= n_valid;
            invalid_verdicts <= n_invalid;
        end
    end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the TCP option validator: clock, reset, option-area stimulus and verdict.
module tb_top;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int TARGET_ITEMS = 1650;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    tov_pkg::in_t  in_data   = '0;
    logic          out_ready = 1'b0;
    logic          in_ready;
    logic          out_valid;
    tov_pkg::out_t out_data;

    int fail_count;
    int pending;
    int valid_verdicts;
    int invalid_verdicts;

    // Percentages of idle sender cycles and stalled receiver cycles per phase.
    int idle_pct[4]  = '{0, 63, 0, 20};
    int stall_pct[4] = '{0, 0, 63, 20};
    int send_idle    = 0;
    int recv_stall   = 0;
    int items_sent   = 0;
    int segments     = 0;
    int quiet_cycles = 0;

    // Transactions of the option area being built.
    tov_pkg::in_t seg_q[$];

    always #HALF_PERIOD clk = ~clk;

    tcp_option_validator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    tov_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data),
        .fail_count       (fail_count),
        .pending          (pending),
        .valid_verdicts   (valid_verdicts),
        .invalid_verdicts (invalid_verdicts)
    );

    // The receiver stalls at random at the rate of the current phase.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall);
    end

    // Watchdog: end the run after too many cycles without any transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [tov_pkg::BYTE_W-1:0] b);
        tov_pkg::in_t t;
        t.action      = tov_pkg::ACT_BYTE;
        t.option_byte = b;
        seg_q.push_back(t);
    endtask

    task automatic push_end();
        tov_pkg::in_t t;
        t.action      = tov_pkg::ACT_END;
        t.option_byte = tov_pkg::BYTE_W'($urandom_range(255));
        seg_q.push_back(t);
        segments++;
    endtask

    // Drive one transaction and hold it until it is accepted.
    task automatic send_item(input tov_pkg::in_t t);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_segment();
        while (seg_q.size() > 0)
            send_item(seg_q.pop_front());
    endtask

    // Build one option area: mostly well-formed options with random content,
    // some corrupted or cut short, and some plain noise.
    task automatic make_segment();
        int mode;
        int n_opts;
        int sel;
        int len_v;
        int tail;
        bit corrupt;
        logic [tov_pkg::BYTE_W-1:0] kind_v;
        mode = $urandom_range(99);
        if (mode < 15)
        begin
            n_opts = $urandom_range(16);
            for (int i = 0; i < n_opts; i++)
                push_byte($urandom_range(1) ? tov_pkg::BYTE_W'($urandom_range(12))
                                            : tov_pkg::BYTE_W'($urandom_range(255)));
        end
        else
        begin
            n_opts = $urandom_range(12);
            for (int i = 0; i < n_opts; i++)
            begin
                sel     = $urandom_range(99);
                corrupt = ($urandom_range(99) < 6);
                if (sel < 20)
                begin
                    push_byte(tov_pkg::KIND_NOP);
                end
                else
                begin
                    if (sel < 40)
                    begin
                        kind_v = tov_pkg::KIND_MSS;
                        len_v  = tov_pkg::LEN_MSS;
                    end
                    else if (sel < 55)
                    begin
                        kind_v = tov_pkg::KIND_WSCALE;
                        len_v  = tov_pkg::LEN_WSCALE;
                    end
                    else if (sel < 65)
                    begin
                        kind_v = tov_pkg::KIND_SACKOK;
                        len_v  = tov_pkg::LEN_SACKOK;
                    end
                    else
                    begin
                        kind_v = tov_pkg::BYTE_W'($urandom_range(255, 5));
                        len_v  = ($urandom_range(99) < 85) ? $urandom_range(12, 2)
                                                           : $urandom_range(40, 2);
                    end
                    if (corrupt)
                        len_v = ($urandom_range(99) < 50) ? $urandom_range(1)
                                                          : $urandom_range(255, 41);
                    if (corrupt && kind_v <= tov_pkg::KIND_SACKOK && $urandom_range(1))
                        len_v = $urandom_range(255);
                    push_byte(kind_v);
                    push_byte(tov_pkg::BYTE_W'(len_v));
                    if (len_v >= tov_pkg::MIN_OPTION_LEN && len_v <= tov_pkg::MAX_OPTION_LEN)
                        for (int j = 0; j < len_v - 2; j++)
                            push_byte(tov_pkg::BYTE_W'($urandom_range(255)));
                end
            end
            // End-of-list with trailing junk, a cut-short option, or nothing.
            tail = $urandom_range(99);
            if (tail < 30)
            begin
                push_byte(tov_pkg::KIND_EOL);
                repeat ($urandom_range(3))
                    push_byte(tov_pkg::BYTE_W'($urandom_range(255)));
            end
            else if (tail < 45)
            begin
                repeat ($urandom_range(3, 1))
                    if (seg_q.size() > 0)
                        void'(seg_q.pop_back());
            end
        end
        push_end();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty area.
        push_end();
        // MSS with extreme values, end-of-list, then a byte that must be ignored.
        push_byte(tov_pkg::KIND_MSS);
        push_byte(tov_pkg::LEN_MSS);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(tov_pkg::KIND_EOL);
        push_byte(8'hAA);
        push_end();
        // Window scale, SACK-permitted and NOP, ended while expecting a kind.
        push_byte(tov_pkg::KIND_WSCALE);
        push_byte(tov_pkg::LEN_WSCALE);
        push_byte(8'd14);
        push_byte(tov_pkg::KIND_SACKOK);
        push_byte(tov_pkg::LEN_SACKOK);
        push_byte(tov_pkg::KIND_NOP);
        push_end();
        // Cut short while expecting the length byte.
        push_byte(tov_pkg::KIND_MSS);
        push_end();
        // Cut short inside the body of an unknown kind.
        push_byte(8'd8);
        push_byte(8'd10);
        push_byte(8'd1);
        push_end();
        // Length beyond the maximum.
        push_byte(8'd5);
        push_byte(8'd41);
        push_end();
        send_segment();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle  = idle_pct[ph];
            recv_stall = stall_pct[ph];
            while (items_sent < (ph + 1) * TARGET_ITEMS / 4)
            begin
                make_segment();
                send_segment();
            end
            // Sender holds off until every verdict so far has come out.
            in_valid <= 1'b0;
            @(negedge clk);
            while (pending != 0)
                @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d transactions in %0d option areas over four idle and stall mixes.",
                 items_sent, segments);
        $display("Verdicts predicted: %0d valid, %0d invalid; failures: %0d.",
                 valid_verdicts, invalid_verdicts, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: tcp_option_validator.f
hdl/tov_pkg.sv
hdl/tov_parser.sv
hdl/tcp_option_validator.sv
dv/tov_checker.sv
dv/tb_top.sv
